// ----- design/bcpe_pkg.sv -----
// Shared constants and types for the cubic Bezier point evaluator.
// No dependencies; every other design file refers to it by scoped names.
package bcpe_pkg;

  // Default fixed-point formats
  localparam int DEF_COORD_FRAC_BITS = 14;
  localparam int DEF_PARAM_FRAC_BITS = 16;

  // Register file geometry
  localparam int NUM_REGS   = 8;
  localparam int REG_IDX_W  = 3;
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  // Number of control points per coordinate
  localparam int NUM_PTS = 4;

  // Pipeline depth: three weight stages, three blend stages
  localparam int WGT_STAGES   = 3;
  localparam int BLEND_STAGES = 3;
  localparam int NUM_STAGES   = WGT_STAGES + BLEND_STAGES;

  // Register indexes, in address order
  typedef enum logic [REG_IDX_W-1:0] {
    REG_P0_X = 3'd0,
    REG_P0_Y = 3'd1,
    REG_P1_X = 3'd2,
    REG_P1_Y = 3'd3,
    REG_P2_X = 3'd4,
    REG_P2_Y = 3'd5,
    REG_P3_X = 3'd6,
    REG_P3_Y = 3'd7
  } reg_idx_t;

  // Per-stage load enables from the pipeline control
  typedef struct packed {
    logic [WGT_STAGES-1:0]   load_wgt;
    logic [BLEND_STAGES-1:0] load_blend;
  } pipe_ctl_t;

endpackage

// ----- design/bcpe_regs.sv -----
// Control-point register file behind an APB-style slave port.
// Depends on bcpe_pkg for register indexes and port widths.
module bcpe_regs #(
  parameter int COORD_FRAC_BITS = bcpe_pkg::DEF_COORD_FRAC_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [bcpe_pkg::APB_ADDR_W-1:0]       paddr,
  input  logic [bcpe_pkg::APB_DATA_W-1:0]       pwdata,
  output logic [bcpe_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                  pready,
  output logic signed [COORD_FRAC_BITS+1:0]     pt_x [bcpe_pkg::NUM_PTS],
  output logic signed [COORD_FRAC_BITS+1:0]     pt_y [bcpe_pkg::NUM_PTS]
);

  localparam int CW = COORD_FRAC_BITS + 2;
  localparam logic signed [CW-1:0] FULL = {2'b01, {COORD_FRAC_BITS{1'b0}}};
  localparam logic signed [CW-1:0] HALF = {3'b001, {(COORD_FRAC_BITS-1){1'b0}}};

  logic signed [CW-1:0]         p0_x_r, p0_y_r, p1_x_r, p1_y_r;
  logic signed [CW-1:0]         p2_x_r, p2_y_r, p3_x_r, p3_y_r;
  logic signed [CW-1:0]         wdata;
  logic signed [CW-1:0]         rdata;
  bcpe_pkg::reg_idx_t           idx;
  logic                         wr_en;

  assign pready = 1'b1;
  assign idx    = bcpe_pkg::reg_idx_t'(paddr[bcpe_pkg::APB_ADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign wdata  = pwdata[CW-1:0];

  // Write the addressed register on the access cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_x_r <= -FULL;
      p0_y_r <= '0;
      p1_x_r <= -HALF;
      p1_y_r <= -HALF;
      p2_x_r <= HALF;
      p2_y_r <= HALF;
      p3_x_r <= FULL;
      p3_y_r <= '0;
    end else if (wr_en) begin
      case (idx)
        bcpe_pkg::REG_P0_X: p0_x_r <= wdata;
        bcpe_pkg::REG_P0_Y: p0_y_r <= wdata;
        bcpe_pkg::REG_P1_X: p1_x_r <= wdata;
        bcpe_pkg::REG_P1_Y: p1_y_r <= wdata;
        bcpe_pkg::REG_P2_X: p2_x_r <= wdata;
        bcpe_pkg::REG_P2_Y: p2_y_r <= wdata;
        bcpe_pkg::REG_P3_X: p3_x_r <= wdata;
        bcpe_pkg::REG_P3_Y: p3_y_r <= wdata;
        default: ;
      endcase
    end
  end

  // Read back the addressed register, sign-extended
  always_comb begin
    case (idx)
      bcpe_pkg::REG_P0_X: rdata = p0_x_r;
      bcpe_pkg::REG_P0_Y: rdata = p0_y_r;
      bcpe_pkg::REG_P1_X: rdata = p1_x_r;
      bcpe_pkg::REG_P1_Y: rdata = p1_y_r;
      bcpe_pkg::REG_P2_X: rdata = p2_x_r;
      bcpe_pkg::REG_P2_Y: rdata = p2_y_r;
      bcpe_pkg::REG_P3_X: rdata = p3_x_r;
      bcpe_pkg::REG_P3_Y: rdata = p3_y_r;
      default:            rdata = '0;
    endcase
  end

  assign prdata = {{(bcpe_pkg::APB_DATA_W-CW){rdata[CW-1]}}, rdata};

  assign pt_x[0] = p0_x_r;
  assign pt_x[1] = p1_x_r;
  assign pt_x[2] = p2_x_r;
  assign pt_x[3] = p3_x_r;
  assign pt_y[0] = p0_y_r;
  assign pt_y[1] = p1_y_r;
  assign pt_y[2] = p2_y_r;
  assign pt_y[3] = p3_y_r;

endmodule

// ----- design/bcpe_ctl.sv -----
// Pipeline flow control: per-stage valid bits and load enables.
// Depends on bcpe_pkg for the stage count and the control struct.
module bcpe_ctl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output bcpe_pkg::pipe_ctl_t ctl
);

  localparam int N = bcpe_pkg::NUM_STAGES;

  logic [N-1:0] valid_r;
  logic [N-1:0] valid_nxt;
  logic [N-1:0] ready;
  logic [N-1:0] load;
  logic [N-1:0] feed;

  // A stage may take new data when empty or when its contents move on
  always_comb begin
    ready[N-1] = ~valid_r[N-1] | ~out_stall;
    for (int k = N - 2; k >= 0; k--) begin
      ready[k] = ~valid_r[k] | ready[k+1];
    end
  end

  assign feed = {valid_r[N-2:0], in_valid};
  assign load = feed & ready;

  // Advance valid bits wherever a stage is ready
  always_comb begin
    for (int k = 0; k < N; k++) begin
      valid_nxt[k] = ready[k] ? feed[k] : valid_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign in_stall       = ~ready[0];
  assign out_valid      = valid_r[N-1];
  assign ctl.load_wgt   = load[bcpe_pkg::WGT_STAGES-1:0];
  assign ctl.load_blend = load[N-1:bcpe_pkg::WGT_STAGES];

endmodule

// ----- design/bcpe_weight.sv -----
// Bernstein weight pipeline: saturate t, square, cube, scale by three.
// Depends on bcpe_pkg for the control struct and point count.
module bcpe_weight #(
  parameter int PARAM_FRAC_BITS = bcpe_pkg::DEF_PARAM_FRAC_BITS
) (
  input  logic                          clk,
  input  bcpe_pkg::pipe_ctl_t           ctl,
  input  logic [PARAM_FRAC_BITS:0]      curve_param,
  output logic [PARAM_FRAC_BITS+2:0]    wgt [bcpe_pkg::NUM_PTS]
);

  localparam int PW = PARAM_FRAC_BITS + 1;
  localparam int WW = PARAM_FRAC_BITS + 3;
  localparam logic [PW-1:0] PARAM_ONE = {1'b1, {PARAM_FRAC_BITS{1'b0}}};

  // Stage A: saturated t and its complement
  logic [PW-1:0]   t_sat;
  logic [PW-1:0]   t_a_r, s_a_r;
  // Stage B: squares
  logic [2*PW-1:0] ss_full, tt_full;
  logic [PW-1:0]   s_b_r, t_b_r, s2_b_r, t2_b_r;
  // Stage C: cubes and cross terms
  logic [2*PW-1:0] sss_full, sst_full, stt_full, ttt_full;
  logic [PW-1:0]   sst, stt;
  logic [WW-1:0]   w0_nxt, w1_nxt, w2_nxt, w3_nxt;
  logic [WW-1:0]   w0_c_r, w1_c_r, w2_c_r, w3_c_r;

  assign t_sat = (curve_param > PARAM_ONE) ? PARAM_ONE : curve_param;

  always_ff @(posedge clk) begin
    if (ctl.load_wgt[0]) begin
      t_a_r <= t_sat;
      s_a_r <= PARAM_ONE - t_sat;
    end
  end

  // Square both terms, floor to Q1.P
  assign ss_full = s_a_r * s_a_r;
  assign tt_full = t_a_r * t_a_r;

  always_ff @(posedge clk) begin
    if (ctl.load_wgt[1]) begin
      s_b_r  <= s_a_r;
      t_b_r  <= t_a_r;
      s2_b_r <= ss_full[PARAM_FRAC_BITS +: PW];
      t2_b_r <= tt_full[PARAM_FRAC_BITS +: PW];
    end
  end

  // Form the four weights; the middle two carry the factor three
  assign sss_full = s2_b_r * s_b_r;
  assign sst_full = s2_b_r * t_b_r;
  assign stt_full = s_b_r * t2_b_r;
  assign ttt_full = t2_b_r * t_b_r;
  assign sst      = sst_full[PARAM_FRAC_BITS +: PW];
  assign stt      = stt_full[PARAM_FRAC_BITS +: PW];
  assign w0_nxt   = WW'(sss_full[PARAM_FRAC_BITS +: PW]);
  assign w1_nxt   = WW'(sst) + (WW'(sst) << 1);
  assign w2_nxt   = WW'(stt) + (WW'(stt) << 1);
  assign w3_nxt   = WW'(ttt_full[PARAM_FRAC_BITS +: PW]);

  always_ff @(posedge clk) begin
    if (ctl.load_wgt[2]) begin
      w0_c_r <= w0_nxt;
      w1_c_r <= w1_nxt;
      w2_c_r <= w2_nxt;
      w3_c_r <= w3_nxt;
    end
  end

  assign wgt[0] = w0_c_r;
  assign wgt[1] = w1_c_r;
  assign wgt[2] = w2_c_r;
  assign wgt[3] = w3_c_r;

endmodule

// ----- design/bcpe_blend.sv -----
// Blend of one coordinate: weight products, adder tree, floor shift, clamp.
// Depends on bcpe_pkg for the control struct and point count.
module bcpe_blend #(
  parameter int COORD_FRAC_BITS = bcpe_pkg::DEF_COORD_FRAC_BITS,
  parameter int PARAM_FRAC_BITS = bcpe_pkg::DEF_PARAM_FRAC_BITS
) (
  input  logic                              clk,
  input  bcpe_pkg::pipe_ctl_t               ctl,
  input  logic [PARAM_FRAC_BITS+2:0]        wgt [bcpe_pkg::NUM_PTS],
  input  logic signed [COORD_FRAC_BITS+1:0] pt [bcpe_pkg::NUM_PTS],
  output logic signed [COORD_FRAC_BITS+1:0] coord
);

  localparam int CW  = COORD_FRAC_BITS + 2;
  localparam int WW  = PARAM_FRAC_BITS + 3;
  localparam int PRW = WW + 1 + CW;
  localparam int SW  = PRW + 1;
  localparam int AW  = PRW + 2;
  localparam logic signed [AW-1:0] LIM_HI = {{(AW-COORD_FRAC_BITS-1){1'b0}}, 1'b1,
                                             {COORD_FRAC_BITS{1'b0}}};
  localparam logic signed [AW-1:0] LIM_LO = -LIM_HI;

  logic signed [PRW-1:0] prod_nxt [bcpe_pkg::NUM_PTS];
  logic signed [PRW-1:0] prod_d_r [bcpe_pkg::NUM_PTS];
  logic signed [SW-1:0]  sum01_e_r, sum23_e_r;
  logic signed [AW-1:0]  acc;
  logic signed [AW-1:0]  acc_sh;
  logic signed [CW-1:0]  coord_nxt;
  logic signed [CW-1:0]  coord_f_r;

  // Multiply each weight by its control point
  always_comb begin
    for (int i = 0; i < bcpe_pkg::NUM_PTS; i++) begin
      prod_nxt[i] = $signed({1'b0, wgt[i]}) * pt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_blend[0]) begin
      prod_d_r <= prod_nxt;
    end
  end

  // First level of the adder tree
  always_ff @(posedge clk) begin
    if (ctl.load_blend[1]) begin
      sum01_e_r <= SW'(prod_d_r[0]) + SW'(prod_d_r[1]);
      sum23_e_r <= SW'(prod_d_r[2]) + SW'(prod_d_r[3]);
    end
  end

  // Final add, floor to coordinate format, clamp to plus or minus one
  assign acc    = AW'(sum01_e_r) + AW'(sum23_e_r);
  assign acc_sh = acc >>> PARAM_FRAC_BITS;

  always_comb begin
    if (acc_sh > LIM_HI) begin
      coord_nxt = LIM_HI[CW-1:0];
    end else if (acc_sh < LIM_LO) begin
      coord_nxt = LIM_LO[CW-1:0];
    end else begin
      coord_nxt = acc_sh[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_blend[2]) begin
      coord_f_r <= coord_nxt;
    end
  end

  assign coord = coord_f_r;

endmodule

// ----- design/cubic_bezier_point_evaluator_unit.sv -----
// Cubic Bezier point evaluator: one curve point per curve parameter.
// Depends on bcpe_pkg, bcpe_regs, bcpe_ctl, bcpe_weight and bcpe_blend.
//
// Usage
//   Control points P0..P3 (signed Q1.COORD_FRAC_BITS) are written over the
//   APB-style port at byte addresses 0,4,..,28 in the order p0_x, p0_y,
//   p1_x, p1_y, p2_x, p2_y, p3_x, p3_y. Write them only while the pipeline
//   is empty. pready is always high and reads return the stored value.
//   Each input transaction carries t in unsigned Q1.PARAM_FRAC_BITS;
//   values above one are taken as one. Each yields exactly one output
//   transaction with the clamped point (x, y), in input order.
//   Pipeline: six register stages (three weight stages, then product,
//   adder-tree and shift/clamp stages per axis). Throughput: one
//   transaction per cycle unless in_stall is high; each stage holds one item.
//   When out_stall is high the output register holds; the stages behind it
//   keep filling any empty slot, and in_stall rises only once every stage
//   is occupied. Reset clears all valid bits and loads the default curve.
module cubic_bezier_point_evaluator_unit #(
  parameter int COORD_FRAC_BITS = bcpe_pkg::DEF_COORD_FRAC_BITS,
  parameter int PARAM_FRAC_BITS = bcpe_pkg::DEF_PARAM_FRAC_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [PARAM_FRAC_BITS:0]           in_curve_param,
  // Output channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [COORD_FRAC_BITS+1:0]  out_point_x,
  output logic signed [COORD_FRAC_BITS+1:0]  out_point_y,
  // Configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [bcpe_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [bcpe_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [bcpe_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready
);

  bcpe_pkg::pipe_ctl_t               ctl;
  logic [PARAM_FRAC_BITS+2:0]        wgt  [bcpe_pkg::NUM_PTS];
  logic signed [COORD_FRAC_BITS+1:0] pt_x [bcpe_pkg::NUM_PTS];
  logic signed [COORD_FRAC_BITS+1:0] pt_y [bcpe_pkg::NUM_PTS];

  // Control-point registers
  bcpe_regs #(
    .COORD_FRAC_BITS(COORD_FRAC_BITS)
  ) u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .pt_x    (pt_x),
    .pt_y    (pt_y)
  );

  // Valid bits and stage enables
  bcpe_ctl u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctl       (ctl)
  );

  // Shared weight pipeline
  bcpe_weight #(
    .PARAM_FRAC_BITS(PARAM_FRAC_BITS)
  ) u_weight (
    .clk         (clk),
    .ctl         (ctl),
    .curve_param (in_curve_param),
    .wgt         (wgt)
  );

  // One blend pipeline per axis
  bcpe_blend #(
    .COORD_FRAC_BITS(COORD_FRAC_BITS),
    .PARAM_FRAC_BITS(PARAM_FRAC_BITS)
  ) u_blend_x (
    .clk   (clk),
    .ctl   (ctl),
    .wgt   (wgt),
    .pt    (pt_x),
    .coord (out_point_x)
  );

  bcpe_blend #(
    .COORD_FRAC_BITS(COORD_FRAC_BITS),
    .PARAM_FRAC_BITS(PARAM_FRAC_BITS)
  ) u_blend_y (
    .clk   (clk),
    .ctl   (ctl),
    .wgt   (wgt),
    .pt    (pt_y),
    .coord (out_point_y)
  );

endmodule
